[sv/olar_pkg.sv]
// ---------------------------------------------------------------------------
// olar_pkg: shared types and constants for the ordered list
// Request and response structs, opcodes, status codes and cell control.
// ---------------------------------------------------------------------------
`default_nettype none

package olar_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned ECNT_W   = 5;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic                    operation;
    logic signed [VAL_W-1:0] value;
    logic        [POS_W-1:0] position;
  } olar_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]  result_value;
    logic        [STAT_W-1:0] status;
    logic        [ECNT_W-1:0] element_count;
  } olar_out_t;

  // Per-cell move command: take the new value, or take the neighbor's value.
  typedef struct packed {
    logic load;
    logic shift;
  } olar_cell_ctrl_t;

endpackage

`default_nettype wire

[sv/olar_cell.sv]
// ---------------------------------------------------------------------------
// olar_cell: one list slot
// Holds one value; loads the appended value or its upper neighbor's value.
// ---------------------------------------------------------------------------
`default_nettype none

module olar_cell (
  input  wire logic                            clk_i,
  input  wire olar_pkg::olar_cell_ctrl_t       ctrl_i,
  input  wire logic signed [olar_pkg::VAL_W-1:0] new_i,
  input  wire logic signed [olar_pkg::VAL_W-1:0] next_i,
  output logic signed [olar_pkg::VAL_W-1:0]      value_o
);

  logic signed [olar_pkg::VAL_W-1:0] value_q;
  logic signed [olar_pkg::VAL_W-1:0] value_d;

  always_comb begin
    priority if (ctrl_i.load) begin
      value_d = new_i;
    end else if (ctrl_i.shift) begin
      value_d = next_i;
    end else begin
      value_d = value_q;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

[sv/ordered_list_append_remove_at_top.sv]
// ---------------------------------------------------------------------------
// ordered_list_append_remove_at_top: bounded ordered list
// Append at the tail, remove at a position with the gap closed by a shift
// along a row of cells. One response per request.
// ---------------------------------------------------------------------------
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i / in_stall_o  | olar_in_t  in_data_i
//   out     | output    | out_valid_o / out_stall_i| olar_out_t out_data_o
//
// One request per cycle while not stalled; each response is registered in the
// output register in the cycle after acceptance. The list update (tail load or
// shift toward the head) completes in the same cycle across all cells.
// Reset clears the element count and the output valid; cell contents are
// undefined until written. While the output register is full and stalled,
// in_stall_o is high and no request is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module ordered_list_append_remove_at_top (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire olar_pkg::olar_in_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output olar_pkg::olar_out_t      out_data_o
);

  localparam int unsigned CAP   = olar_pkg::CAPACITY;
  localparam int unsigned CNT_W = olar_pkg::CNT_W;

  logic [CNT_W-1:0]                  count_q, count_d;
  logic                              out_valid_q, out_valid_d;
  olar_pkg::olar_out_t               out_data_q, out_data_d;
  logic                              in_acc;
  logic                              is_append, append_ok, remove_ok;
  olar_pkg::olar_cell_ctrl_t         ctrl [CAP];
  logic signed [olar_pkg::VAL_W-1:0] cell_val [CAP];
  logic signed [olar_pkg::VAL_W-1:0] read_val;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign is_append  = (in_data_i.operation == olar_pkg::OP_APPEND);
  assign append_ok  = is_append & (32'(count_q) < CAP);
  assign remove_ok  = ~is_append & (32'(in_data_i.position) < 32'(count_q));

  // Row of cells: each one takes the new value or its upper neighbor's.
  for (genvar i = 0; i < CAP; i++) begin : g_cell
    assign ctrl[i].load  = in_acc & append_ok & (32'(count_q) == i);
    assign ctrl[i].shift = in_acc & remove_ok & (i >= 32'(in_data_i.position))
                           & (i + 1 < 32'(count_q));

    if (i + 1 < CAP) begin : g_mid
      olar_cell u_cell (
        .clk_i  (clk_i),
        .ctrl_i (ctrl[i]),
        .new_i  (in_data_i.value),
        .next_i (cell_val[i+1]),
        .value_o(cell_val[i])
      );
    end else begin : g_last
      olar_cell u_cell (
        .clk_i  (clk_i),
        .ctrl_i (ctrl[i]),
        .new_i  (in_data_i.value),
        .next_i ('0),
        .value_o(cell_val[i])
      );
    end
  end

  // Positions past the row never pass the range check; guard the index anyway.
  always_comb begin
    read_val = '0;
    for (int unsigned k = 0; k < CAP; k++) begin
      if (32'(in_data_i.position) == k) begin
        read_val = cell_val[k];
      end
    end
  end

  always_comb begin
    count_d     = count_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_data_d  = out_data_q;
    if (in_acc) begin
      out_valid_d = 1'b1;
      out_data_d.result_value = '0;
      out_data_d.status       = olar_pkg::ST_OK;
      if (is_append) begin
        if (append_ok) begin
          count_d                 = count_q + CNT_W'(1);
          out_data_d.result_value = in_data_i.value;
        end else begin
          out_data_d.status = olar_pkg::ST_FULL;
        end
      end else begin
        if (remove_ok) begin
          count_d                 = count_q - CNT_W'(1);
          out_data_d.result_value = read_val;
        end else begin
          out_data_d.status = olar_pkg::ST_RANGE;
        end
      end
      out_data_d.element_count = olar_pkg::ECNT_W'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= CAP)
    else $error("element count above capacity");

  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && append_ok |=> 32'(count_q) == 32'($past(count_q)) + 1)
    else $error("accepted append did not grow the list");

  a_error_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !append_ok && !remove_ok |=> $stable(count_q))
    else $error("rejected request changed the count");

  a_resp_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q && out_data_q.element_count == olar_pkg::ECNT_W'(count_q))
    else $error("response count differs from list count");
`endif

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: ordered list with append and remove-at-position
// Walks a short table of directed requests, then random fill, drain and mixed
// runs with random gaps on both channels. Each response is compared against
// its table entry or a shadow copy of the list kept in the testbench.
// ---------------------------------------------------------------------------

module testbench;

  localparam int unsigned RANDOM_ITEMS = 1725;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PRINT_LIMIT  = 40;

  typedef struct {
    olar_pkg::olar_in_t  req;
    bit                  typed;
    olar_pkg::olar_out_t rsp;
  } list_case_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  olar_pkg::olar_in_t  in_data_i   = '0;
  logic                out_stall_i = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  olar_pkg::olar_out_t out_data_o;

  // shadow of the list contents
  logic signed [olar_pkg::VAL_W-1:0] shadow_vals [olar_pkg::CAPACITY];
  int unsigned                       held_count = 0;

  olar_pkg::olar_out_t pending_rsps [$];
  list_case_t          directed_cases [$];
  int unsigned         mismatch_count = 0;
  int unsigned         cycle_count    = 0;
  int unsigned         rsp_count      = 0;
  int                  recv_wait      = 0;
  bit                  recv_quiet     = 1'b0;
  bit                  send_quiet     = 1'b0;

  ordered_list_append_remove_at_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    if (mismatch_count < PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic olar_pkg::olar_out_t make_rsp(logic signed [olar_pkg::VAL_W-1:0] v,
                                                   logic [olar_pkg::STAT_W-1:0] st,
                                                   int unsigned cnt);
    olar_pkg::olar_out_t rsp;
    rsp.result_value  = v;
    rsp.status        = st;
    rsp.element_count = cnt[olar_pkg::ECNT_W-1:0];
    return rsp;
  endfunction

  // Apply one request to the shadow list and return the response it yields.
  function automatic olar_pkg::olar_out_t apply_list_op(olar_pkg::olar_in_t req);
    olar_pkg::olar_out_t rsp;
    rsp = make_rsp('0, olar_pkg::ST_OK, 0);
    if (req.operation == olar_pkg::OP_APPEND) begin
      if (held_count >= olar_pkg::CAPACITY) begin
        rsp.status = olar_pkg::ST_FULL;
      end else begin
        shadow_vals[held_count] = req.value;
        held_count++;
        rsp.result_value = req.value;
      end
    end else begin
      if (req.position >= held_count) begin
        rsp.status = olar_pkg::ST_RANGE;
      end else begin
        rsp.result_value = shadow_vals[req.position];
        // close the gap toward the head
        for (int i = req.position; i + 1 < held_count; i++)
          shadow_vals[i] = shadow_vals[i + 1];
        held_count--;
      end
    end
    rsp.element_count = held_count[olar_pkg::ECNT_W-1:0];
    return rsp;
  endfunction

  task automatic add_case(logic op, logic signed [olar_pkg::VAL_W-1:0] v,
                          logic [olar_pkg::POS_W-1:0] pos, bit typed,
                          olar_pkg::olar_out_t rsp);
    list_case_t c;
    c.req.operation = op;
    c.req.value     = v;
    c.req.position  = pos;
    c.typed         = typed;
    c.rsp           = rsp;
    directed_cases.push_back(c);
  endtask

  // Present one request after a random gap and hold it until taken.
  task automatic send_request(olar_pkg::olar_in_t req, bit typed, olar_pkg::olar_out_t rsp);
    int                  gap;
    olar_pkg::olar_out_t predicted;
    gap = send_quiet ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    predicted = apply_list_op(req);
    pending_rsps.push_back(typed ? rsp : predicted);
  endtask

  task automatic wait_for_idle();
    in_valid_i <= 1'b0;
    while (pending_rsps.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_segment(output int unsigned sent);
    int                 kind;
    int                 pick;
    int unsigned        n;
    olar_pkg::olar_in_t req;
    kind       = $urandom_range(0, 3);
    send_quiet = ($urandom_range(0, 3) == 0);
    if (kind == 0) n = olar_pkg::CAPACITY - held_count + 1;
    else if (kind == 1) n = held_count + 1;
    else n = 24;
    sent = n;
    repeat (n) begin
      req.value     = $urandom();
      req.position  = $urandom_range(0, 15);
      req.operation = olar_pkg::OP_REMOVE;
      case (kind)
        0: req.operation = olar_pkg::OP_APPEND;
        1: begin
          if (held_count != 0) req.position = $urandom_range(0, held_count - 1);
        end
        default: begin
          pick = $urandom_range(0, 7);
          if (pick < 4) req.operation = olar_pkg::OP_APPEND;
          else if (pick < 7 && held_count != 0)
            req.position = $urandom_range(0, held_count - 1);
        end
      endcase
      send_request(req, 1'b0, '0);
    end
  endtask

  // Receiver: random stall per response, compare against the oldest expected response.
  always @(posedge clk_i) begin
    olar_pkg::olar_out_t exp_rsp;
    if (out_valid_o && !out_stall_i) begin
      if (pending_rsps.size() == 0) begin
        report_mismatch($sformatf("response with none expected: value %0d status %0d count %0d",
                                  out_data_o.result_value, out_data_o.status,
                                  out_data_o.element_count));
      end else begin
        exp_rsp = pending_rsps.pop_front();
        if (out_data_o.result_value !== exp_rsp.result_value)
          report_mismatch($sformatf("result_value %0d, expected %0d",
                                    out_data_o.result_value, exp_rsp.result_value));
        if (out_data_o.status !== exp_rsp.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    out_data_o.status, exp_rsp.status));
        if (out_data_o.element_count !== exp_rsp.element_count)
          report_mismatch($sformatf("element_count %0d, expected %0d",
                                    out_data_o.element_count, exp_rsp.element_count));
      end
      rsp_count++;
      if (rsp_count % 40 == 0) recv_quiet = ($urandom_range(0, 2) == 0);
      recv_wait = recv_quiet ? 0 : $urandom_range(0, 19);
      out_stall_i <= (recv_wait != 0);
    end else if (recv_wait != 0) begin
      recv_wait--;
      out_stall_i <= (recv_wait != 0);
    end
  end

  initial begin
    int unsigned random_sent;
    int unsigned seg_sent;
    logic signed [olar_pkg::VAL_W-1:0] fill_val;

    // empty list, extremes, fill to capacity, full, then tail/head/middle removal
    add_case(olar_pkg::OP_REMOVE, 32'sd0, 4'd0, 1'b1,
             make_rsp('0, olar_pkg::ST_RANGE, 0));
    add_case(olar_pkg::OP_REMOVE, 32'sd7, 4'd15, 1'b1,
             make_rsp('0, olar_pkg::ST_RANGE, 0));
    add_case(olar_pkg::OP_APPEND, 32'h8000_0000, 4'd9, 1'b1,
             make_rsp(32'h8000_0000, olar_pkg::ST_OK, 1));
    add_case(olar_pkg::OP_APPEND, 32'h7FFF_FFFF, 4'd0, 1'b1,
             make_rsp(32'h7FFF_FFFF, olar_pkg::ST_OK, 2));
    add_case(olar_pkg::OP_REMOVE, 32'sd0, 4'd2, 1'b1,
             make_rsp('0, olar_pkg::ST_RANGE, 2));
    for (int k = 0; k < 14; k++) begin
      case (k)
        0:       fill_val = 32'hFFFF_FFFF;
        1:       fill_val = 32'h0000_0000;
        2:       fill_val = 32'h5555_5555;
        3:       fill_val = 32'hAAAA_AAAA;
        default: fill_val = k * 32'h0101_0101;
      endcase
      add_case(olar_pkg::OP_APPEND, fill_val, k[olar_pkg::POS_W-1:0], 1'b1,
               make_rsp(fill_val, olar_pkg::ST_OK, 3 + k));
    end
    add_case(olar_pkg::OP_APPEND, 32'sd123, 4'd15, 1'b1,
             make_rsp('0, olar_pkg::ST_FULL, olar_pkg::CAPACITY));
    add_case(olar_pkg::OP_REMOVE, 32'sd0, 4'd15, 1'b0, '0);
    add_case(olar_pkg::OP_REMOVE, 32'sd0, 4'd0, 1'b0, '0);
    add_case(olar_pkg::OP_REMOVE, 32'h1234_5678, 4'd6, 1'b0, '0);
    add_case(olar_pkg::OP_APPEND, 32'sd0, 4'd15, 1'b0, '0);
    add_case(olar_pkg::OP_REMOVE, 32'hFFFF_0000, 4'd13, 1'b0, '0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_cases[i])
      send_request(directed_cases[i].req, directed_cases[i].typed, directed_cases[i].rsp);

    // hold off until the list has answered everything
    wait_for_idle();

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      run_segment(seg_sent);
      random_sent += seg_sent;
      if ($urandom_range(0, 7) == 0) wait_for_idle();
    end

    wait_for_idle();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

[ordered_list_append_remove_at_top.f]
sv/olar_pkg.sv
sv/olar_cell.sv
sv/ordered_list_append_remove_at_top.sv
test/testbench.sv
